// ===== hdl/order_book_price_level_table_defines.svh =====
// Assertion macros used by the order book price level table datapath.
`ifndef ORDER_BOOK_PRICE_LEVEL_TABLE_DEFINES_SVH
`define ORDER_BOOK_PRICE_LEVEL_TABLE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define OB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define OB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/obplt_pkg.sv =====
// Shared constants, codes and command types of the order book price level table.
package obplt_pkg;

	localparam int unsigned LEVELS     = 64;
	localparam int unsigned IDX_W      = $clog2(LEVELS);
	localparam int unsigned PRICE_W    = 32;
	localparam int unsigned QTY_W      = 32;
	localparam int unsigned SPREAD_W   = 33;
	localparam int unsigned S_TDATA_W  = 64;
	localparam int unsigned M_TDATA_W  = 104;
	localparam int unsigned M_TUSER_W  = 3;
	localparam int unsigned M_PAD_W    = M_TDATA_W - (2 * PRICE_W + SPREAD_W + 2);

	typedef enum logic [M_TUSER_W-1:0] {
		ST_REPLACED = 3'd0,
		ST_INSERTED = 3'd1,
		ST_ERASED   = 3'd2,
		ST_ABSENT   = 3'd3,
		ST_FULL     = 3'd4
	} upd_status_t;

	typedef struct packed {
		logic             start;
		logic             issue;
		logic [IDX_W-1:0] addr;
		logic             finish;
		logic             load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_stat_t;

endpackage

// ===== hdl/order_book_price_level_table.sv =====
// Top level of the order book price level table: bid and ask price levels with best prices.
//
// Channel  Dir  Fields
// s_*      in   tuser: side; tdata: price_ticks[31:0], quantity[63:32]
// m_*      out  tuser: status; tdata: best_bid, best_ask, spread, bid_present, ask_present
//
// Each update scans all LEVELS entries of both price memories through one read port
// each, one entry a cycle, then applies the update and loads the result register.
// The next input is taken only after the result is loaded and the controller is idle.
// Reset clears the used bits at once; there is no clearing pass.
// A stalled output holds the result while the next update is scanned.
module order_book_price_level_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [obplt_pkg::S_TDATA_W-1:0]   s_tdata,  // price_ticks, quantity
	input  logic                              s_tuser,  // side
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [obplt_pkg::M_TDATA_W-1:0]   m_tdata,  // best_bid, best_ask, spread,
	                                                    // bid_present, ask_present, zero fill
	output logic [obplt_pkg::M_TUSER_W-1:0]   m_tuser   // status
);
	import obplt_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	obplt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	obplt_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== hdl/obplt_ctrl.sv =====
// Controller that sequences the table scan, the update and the result load.
module obplt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output obplt_pkg::ctrl_cmd_t cmd,
	input  obplt_pkg::dp_stat_t  stat
);
	import obplt_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_DRAIN  = 5'b00100,
		S_FINISH = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] cnt_q;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.start    = s_tvalid && s_tready;
		cmd.issue    = (state_q == S_SCAN);
		cmd.addr     = cnt_q;
		cmd.finish   = (state_q == S_FINISH);
		cmd.load_out = (state_q == S_RESULT) && !stat.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					if (cnt_q == IDX_W'(LEVELS - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!stat.out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/obplt_dpath.sv =====
// Datapath with the price memories, used bits, scan accumulators and output register.
`include "order_book_price_level_table_defines.svh"

module obplt_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  obplt_pkg::ctrl_cmd_t              cmd,
	output obplt_pkg::dp_stat_t               stat,
	input  logic [obplt_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [obplt_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [obplt_pkg::M_TUSER_W-1:0]   m_tuser
);
	import obplt_pkg::*;

	logic [PRICE_W-1:0] bid_mem [LEVELS];
	logic [PRICE_W-1:0] ask_mem [LEVELS];
	logic [LEVELS-1:0]  bid_used_q;
	logic [LEVELS-1:0]  ask_used_q;

	logic               side_q;
	logic [PRICE_W-1:0] price_q;
	logic               erase_q;

	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               bused_s1;
	logic               aused_s1;
	logic [PRICE_W-1:0] bprice_s1;
	logic [PRICE_W-1:0] aprice_s1;

	logic               match_q;
	logic [IDX_W-1:0]   match_idx_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               bid_any_q;
	logic [PRICE_W-1:0] bid_best_q;
	logic               ask_any_q;
	logic [PRICE_W-1:0] ask_best_q;
	upd_status_t        st_q;

	logic               sel_used;
	logic [PRICE_W-1:0] sel_price;
	logic               bid_take;
	logic               ask_take;
	logic               ins_en;
	logic               del_en;
	logic               incl_new;
	upd_status_t        st_d;
	logic [SPREAD_W-1:0] spread;
	logic [LEVELS-1:0]  sel_used_vec;

	assign stat.out_busy = m_tvalid && !m_tready;
	assign sel_used_vec  = side_q ? ask_used_q : bid_used_q;

	always_comb begin
		sel_used  = side_q ? aused_s1 : bused_s1;
		sel_price = side_q ? aprice_s1 : bprice_s1;
		bid_take  = bused_s1 && !(!side_q && (bprice_s1 == price_q))
			&& (!bid_any_q || (bprice_s1 > bid_best_q));
		ask_take  = aused_s1 && !(side_q && (aprice_s1 == price_q))
			&& (!ask_any_q || (aprice_s1 < ask_best_q));
		ins_en    = cmd.finish && !erase_q && !match_q && free_q;
		del_en    = cmd.finish && erase_q && match_q;
		incl_new  = !erase_q && (match_q || free_q);
		if (erase_q) begin
			st_d = match_q ? ST_ERASED : ST_ABSENT;
		end else if (match_q) begin
			st_d = ST_REPLACED;
		end else if (free_q) begin
			st_d = ST_INSERTED;
		end else begin
			st_d = ST_FULL;
		end
		if ((bid_best_q != '0) && (ask_best_q != '0)) begin
			spread = {1'b0, ask_best_q} - {1'b0, bid_best_q};
		end else begin
			spread = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			bprice_s1 <= bid_mem[cmd.addr];
			aprice_s1 <= ask_mem[cmd.addr];
		end
		if (ins_en && !side_q) begin
			bid_mem[free_idx_q] <= price_q;
		end
		if (ins_en && side_q) begin
			ask_mem[free_idx_q] <= price_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			side_q  <= s_tuser;
			price_q <= s_tdata[PRICE_W-1:0];
			erase_q <= (s_tdata[S_TDATA_W-1:PRICE_W] == '0) || s_tdata[S_TDATA_W-1];
		end
		if (cmd.issue) begin
			idx_s1   <= cmd.addr;
			bused_s1 <= bid_used_q[cmd.addr];
			aused_s1 <= ask_used_q[cmd.addr];
		end
		if (cmd.finish) begin
			st_q <= st_d;
		end
		if (cmd.load_out) begin
			m_tdata <= {{M_PAD_W{1'b0}}, ask_any_q, bid_any_q, spread, ask_best_q, bid_best_q};
			m_tuser <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_used_q  <= '0;
			ask_used_q  <= '0;
			vld_s1      <= 1'b0;
			match_q     <= 1'b0;
			match_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			bid_any_q   <= 1'b0;
			bid_best_q  <= '0;
			ask_any_q   <= 1'b0;
			ask_best_q  <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.start) begin
				match_q    <= 1'b0;
				free_q     <= 1'b0;
				bid_any_q  <= 1'b0;
				bid_best_q <= '0;
				ask_any_q  <= 1'b0;
				ask_best_q <= '0;
			end else if (vld_s1) begin
				if (sel_used && (sel_price == price_q) && !match_q) begin
					match_q     <= 1'b1;
					match_idx_q <= idx_s1;
				end
				if (!sel_used && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
				if (bid_take) begin
					bid_any_q  <= 1'b1;
					bid_best_q <= bprice_s1;
				end
				if (ask_take) begin
					ask_any_q  <= 1'b1;
					ask_best_q <= aprice_s1;
				end
			end else if (cmd.finish && incl_new) begin
				if (!side_q) begin
					bid_any_q <= 1'b1;
					if (!bid_any_q || (price_q > bid_best_q)) begin
						bid_best_q <= price_q;
					end
				end else begin
					ask_any_q <= 1'b1;
					if (!ask_any_q || (price_q < ask_best_q)) begin
						ask_best_q <= price_q;
					end
				end
			end
			if (ins_en && !side_q) begin
				bid_used_q[free_idx_q] <= 1'b1;
			end
			if (ins_en && side_q) begin
				ask_used_q[free_idx_q] <= 1'b1;
			end
			if (del_en && !side_q) begin
				bid_used_q[match_idx_q] <= 1'b0;
			end
			if (del_en && side_q) begin
				ask_used_q[match_idx_q] <= 1'b0;
			end
			if (cmd.load_out) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	`OB_ASSERT_NOW(a_load_free, cmd.load_out, !m_tvalid || m_tready, "result loaded over a pending transaction")
	`OB_ASSERT_NOW(a_scan_drained, cmd.finish, !vld_s1 && !cmd.issue, "update applied before the scan drained")
	`OB_ASSERT_NEXT(a_ins_grows, ins_en, $countones(sel_used_vec) == $past($countones(sel_used_vec)) + 1, "insert did not add exactly one level")
	`OB_ASSERT_NEXT(a_del_shrinks, del_en, $countones(sel_used_vec) + 1 == $past($countones(sel_used_vec)), "erase did not remove exactly one level")

endmodule

// ===== tb/sv/obplt_quote_checker.sv =====
// Checker that predicts and compares the quotes of the order book price level table.
module obplt_quote_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [obplt_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [obplt_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [obplt_pkg::M_TUSER_W-1:0] m_tuser,
	output int                              pending,
	output int                              fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import obplt_pkg::*;

	typedef struct {
		logic [PRICE_W-1:0]  best_bid;
		logic [PRICE_W-1:0]  best_ask;
		logic [SPREAD_W-1:0] spread;
		logic                bid_present;
		logic                ask_present;
		upd_status_t         status;
	} book_quote_t;

	logic [PRICE_W-1:0] level_price [2][LEVELS];
	logic [QTY_W-1:0]   level_size  [2][LEVELS];
	logic               level_used  [2][LEVELS];
	book_quote_t        expected_quotes [$];
	int                 err_cnt = 0;

	initial pending = 0;
	assign fail_count = err_cnt;

	function automatic book_quote_t predict_quote(logic side, logic [PRICE_W-1:0] price,
			logic [QTY_W-1:0] qty);
		book_quote_t q;
		int hit;
		int slot;
		logic positive;
		logic any_bid;
		logic any_ask;
		logic [PRICE_W-1:0] bb;
		logic [PRICE_W-1:0] ba;
		hit = -1;
		slot = -1;
		positive = (qty != '0) && !qty[QTY_W-1];
		for (int i = 0; i < LEVELS; i++) begin
			if (level_used[side][i]) begin
				if (hit < 0 && level_price[side][i] == price)
					hit = i;
			end else if (slot < 0) begin
				slot = i;
			end
		end
		if (positive && hit >= 0) begin
			level_size[side][hit] = qty;
			q.status = ST_REPLACED;
		end else if (positive && slot >= 0) begin
			level_price[side][slot] = price;
			level_size[side][slot] = qty;
			level_used[side][slot] = 1'b1;
			q.status = ST_INSERTED;
		end else if (positive) begin
			q.status = ST_FULL;
		end else if (hit >= 0) begin
			level_used[side][hit] = 1'b0;
			q.status = ST_ERASED;
		end else begin
			q.status = ST_ABSENT;
		end
		bb = '0;
		ba = '0;
		any_bid = 1'b0;
		any_ask = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			if (level_used[0][i]) begin
				if (!any_bid || level_price[0][i] > bb)
					bb = level_price[0][i];
				any_bid = 1'b1;
			end
			if (level_used[1][i]) begin
				if (!any_ask || level_price[1][i] < ba)
					ba = level_price[1][i];
				any_ask = 1'b1;
			end
		end
		q.best_bid = bb;
		q.best_ask = ba;
		q.bid_present = any_bid;
		q.ask_present = any_ask;
		q.spread = (bb != '0 && ba != '0) ? {1'b0, ba} - {1'b0, bb} : '0;
		return q;
	endfunction

	task automatic report_field(string field, logic [SPREAD_W-1:0] want,
			logic [SPREAD_W-1:0] got);
		if (want !== got) begin
			err_cnt++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		book_quote_t want;
		if (!arst_n) begin
			for (int s = 0; s < 2; s++)
				for (int i = 0; i < LEVELS; i++)
					level_used[s][i] = 1'b0;
			expected_quotes.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_quotes.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected transaction, expected none, actual %h %h",
						$time, m_tuser, m_tdata);
				end else begin
					want = expected_quotes.pop_front();
					report_field("best_bid", SPREAD_W'(want.best_bid),
						SPREAD_W'(m_tdata[31:0]));
					report_field("best_ask", SPREAD_W'(want.best_ask),
						SPREAD_W'(m_tdata[63:32]));
					report_field("spread", want.spread, m_tdata[96:64]);
					report_field("bid_present", SPREAD_W'(want.bid_present),
						SPREAD_W'(m_tdata[97]));
					report_field("ask_present", SPREAD_W'(want.ask_present),
						SPREAD_W'(m_tdata[98]));
					report_field("status", SPREAD_W'(want.status), SPREAD_W'(m_tuser));
				end
			end
			if (s_tvalid && s_tready)
				expected_quotes.insert(expected_quotes.size(),
					predict_quote(s_tuser, s_tdata[31:0], s_tdata[63:32]));
		end
		pending <= expected_quotes.size();
	end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top that drives updates into the order book price level table and gives the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import obplt_pkg::*;

	localparam int FILL_N   = LEVELS + 4;
	localparam int WATCHDOG = 1000;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	int pending;
	int fail_count;
	int sent = 0;
	int idle_cycles = 0;
	int rx_wait = 0;
	int rx_next;
	logic rx_calm = 1'b0;
	logic tx_calm = 1'b0;

	always #5 clk = ~clk;

	order_book_price_level_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	obplt_quote_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.pending(pending),
		.fail_count(fail_count)
	);

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if ($urandom_range(0, 31) == 0)
					rx_calm <= !rx_calm;
				rx_next = rx_calm ? 0 : $urandom_range(0, 18);
			end else begin
				rx_next = (rx_wait > 0) ? rx_wait - 1 : 0;
			end
			rx_wait <= rx_next;
			m_tready <= (rx_next == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic logic [QTY_W-1:0] draw_quantity();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return $urandom | 32'h8000_0000;
			default: return {1'b0, 31'($urandom)};
		endcase
	endfunction

	task automatic send_update(logic side, logic [PRICE_W-1:0] price, logic [QTY_W-1:0] qty);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= side;
		s_tdata <= {qty, price};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic drain_quotes();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// Inserts more distinct prices than a side holds, then erases them all in a scattered order.
	task automatic fill_side(logic side);
		logic [PRICE_W-1:0] base;
		int step;
		int stride;
		int off;
		base = $urandom;
		step = $urandom_range(1, 4096);
		stride = 2 * $urandom_range(0, 7) + 1;
		off = $urandom_range(0, FILL_N - 1);
		tx_calm = 1'($urandom_range(0, 1));
		for (int k = 0; k < FILL_N; k++) begin
			send_update(side, base + k * step, $urandom_range(1, 32'h7FFF_FFFF));
			if (k > 0 && $urandom_range(0, 7) == 0)
				send_update(side, base + $urandom_range(0, k - 1) * step,
					$urandom_range(1, 32'h7FFF_FFFF));
		end
		for (int k = 0; k < FILL_N; k++)
			send_update(side, base + ((k * stride + off) % FILL_N) * step,
				$urandom_range(0, 1) ? 32'h0 : ($urandom | 32'h8000_0000));
	endtask

	initial begin : stimulus
		logic [PRICE_W-1:0] pool [6];
		logic side;
		logic [PRICE_W-1:0] price;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_update(1'b0, 32'd5, 32'h0);
		send_update(1'b1, 32'd5, 32'hFFFF_FFFF);
		send_update(1'b0, 32'd100, 32'h7FFF_FFFF);
		send_update(1'b1, 32'hFFFF_FFFF, 32'h1);
		send_update(1'b0, 32'd100, 32'h100);
		send_update(1'b1, 32'h0, 32'd10);
		send_update(1'b0, 32'hFFFF_FFFF, 32'd5);
		send_update(1'b1, 32'h0, 32'h8000_0000);
		send_update(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_update(1'b1, 32'd50, 32'd3);
		send_update(1'b0, 32'h0, 32'h1);
		send_update(1'b0, 32'd100, 32'h0);
		send_update(1'b0, 32'h0, 32'h8000_0001);
		send_update(1'b1, 32'd50, 32'h0);
		send_update(1'b1, 32'hFFFF_FFFF, 32'h0);
		send_update(1'b1, 32'hFFFF_FFFF, 32'h0);
		drain_quotes();

		fill_side(1'b0);
		fill_side(1'b1);

		while (sent < 550) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			foreach (pool[k])
				pool[k] = $urandom;
			pool[0] = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
			repeat (30) begin
				side = 1'($urandom_range(0, 1));
				price = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 5)] : $urandom;
				send_update(side, price, draw_quantity());
			end
			if ($urandom_range(0, 2) == 0)
				drain_quotes();
		end

		drain_quotes();
		repeat (LEVELS + 16) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
